### rtl/ite_pkg.sv
// ============================================================================
// ite_pkg: shared types and constants for the I-type execute unit
// Item layouts, operation and instruction field codes, pipeline stage record.
// ============================================================================
package ite_pkg;

   localparam int unsigned MEM_DEPTH_DEF = 65536;
   localparam int unsigned NUM_LANES     = 4;
   localparam int unsigned XLEN          = 32;
   localparam int unsigned REG_IDX_W     = 5;

   // Operation codes of an input item
   localparam logic [1:0] OP_EXEC   = 2'd0;
   localparam logic [1:0] OP_MEM_WR = 2'd1;
   localparam logic [1:0] OP_REG_WR = 2'd2;

   // Major opcodes
   localparam logic [6:0] OPC_LOAD  = 7'h03;
   localparam logic [6:0] OPC_OPIMM = 7'h13;
   localparam logic [6:0] OPC_JALR  = 7'h67;

   // OP-IMM funct3
   localparam logic [2:0] F3_ADDI  = 3'd0;
   localparam logic [2:0] F3_SLLI  = 3'd1;
   localparam logic [2:0] F3_SLTI  = 3'd2;
   localparam logic [2:0] F3_SLTIU = 3'd3;
   localparam logic [2:0] F3_XORI  = 3'd4;
   localparam logic [2:0] F3_SRXI  = 3'd5;
   localparam logic [2:0] F3_ORI   = 3'd6;

   // Load funct3
   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;

   localparam logic [2:0] F3_JALR = 3'd0;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_SRA  = 7'h20;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] instruction;
      logic [31:0] current_pc;
      logic [15:0] host_address;
      logic [31:0] host_data;
   } req_type;

   typedef struct packed {
      logic        reg_written;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic [31:0] next_pc;
      logic        status;
   } rsp_type;

   // One item as it travels behind the execute stage
   typedef struct packed {
      logic                 rf_we;
      logic [REG_IDX_W-1:0] rf_idx;
      logic [XLEN-1:0]      rf_val;
      logic                 out_wr;
      logic                 is_load;
      logic [2:0]           ld_f3;
      logic                 host_mem;
      logic [7:0]           host_byte;
      logic [XLEN-1:0]      npc;
      logic                 status;
   } pipe_type;

endpackage

### rtl/ite_regfile.sv
// ============================================================================
// ite_regfile: 32 x 32 register file
// Synchronous read, write-first bypass, valid bits so unwritten entries read 0.
// ============================================================================
module ite_regfile (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ite_pkg::REG_IDX_W-1:0] rd_idx,
   output logic [ite_pkg::XLEN-1:0]      rd_data_ff,
   input  logic                         wr_en,
   input  logic [ite_pkg::REG_IDX_W-1:0] wr_idx,
   input  logic [ite_pkg::XLEN-1:0]      wr_data
);
   import ite_pkg::*;

   localparam int unsigned NumRegs = 2 ** REG_IDX_W;

   logic [XLEN-1:0] mem [NumRegs];
   logic [NumRegs-1:0] valid_ff;
   logic [NumRegs-1:0] valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      // same-edge write wins so a reader never misses a retiring item
      if (wr_en && (wr_idx == rd_idx)) begin
         rd_data_ff <= wr_data;
      end else if (valid_ff[rd_idx]) begin
         rd_data_ff <= mem[rd_idx];
      end else begin
         rd_data_ff <= '0;
      end
   end

endmodule

### rtl/ite_addr_mod.sv
// ============================================================================
// ite_addr_mod: byte address reduction
// Four-stage pipe: effective address modulo depth, then the four byte lanes.
// ============================================================================
module ite_addr_mod #(
   parameter int unsigned MEM_DEPTH = ite_pkg::MEM_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [ite_pkg::XLEN-1:0]      ea_in,
   output logic [$clog2(MEM_DEPTH)-1:0] lane_addr_ff [ite_pkg::NUM_LANES]
);
   import ite_pkg::*;

   localparam int unsigned AW    = $clog2(MEM_DEPTH);
   localparam int unsigned Shift = XLEN + AW;
   // floor(2^Shift / depth): the quotient estimate is low by at most one
   localparam logic [63:0] Recip64 = (64'd1 << Shift) / 64'(MEM_DEPTH);
   localparam logic [XLEN:0] Recip = Recip64[XLEN:0];
   localparam logic [XLEN-1:0] Depth32 = XLEN'(MEM_DEPTH);
   localparam logic [AW:0] DepthW = (AW + 1)'(MEM_DEPTH);

   logic [XLEN-1:0] q_ff, ea1_ff, qd_ff, ea2_ff, ea3_ff;
   logic [AW-1:0]   r_ff;
   logic [2*XLEN:0] prod;
   logic [2*XLEN-1:0] qd_full;
   logic [XLEN-1:0] diff, r_in;
   logic [AW-1:0]   lane_in [NUM_LANES];

   assign prod    = (2 * XLEN + 1)'(ea_in) * (2 * XLEN + 1)'(Recip);
   assign qd_full = (2 * XLEN)'(q_ff) * (2 * XLEN)'(Depth32);
   assign diff    = ea2_ff - qd_ff;
   assign r_in    = (diff >= Depth32) ? (diff - Depth32) : diff;

   always_comb begin
      logic [AW:0]     sum;
      logic [XLEN-1:0] wrap;
      for (int k = 0; k < NUM_LANES; k++) begin
         sum  = {1'b0, r_ff} + (AW + 1)'(k);
         wrap = ea3_ff + XLEN'(k);
         if (ea3_ff > ({XLEN{1'b1}} - XLEN'(k))) begin
            // address rolled past 2^32: lands on a small byte index
            lane_in[k] = wrap[AW-1:0];
         end else if (sum >= DepthW) begin
            lane_in[k] = AW'(sum - DepthW);
         end else begin
            lane_in[k] = sum[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff   <= XLEN'(prod >> Shift);
         ea1_ff <= ea_in;
         qd_ff  <= qd_full[XLEN-1:0];
         ea2_ff <= ea1_ff;
         r_ff   <= r_in[AW-1:0];
         ea3_ff <= ea2_ff;
         lane_addr_ff <= lane_in;
      end
   end

endmodule

### rtl/ite_data_mem.sv
// ============================================================================
// ite_data_mem: byte data memory
// Four identical byte copies, one read port each, so a whole word reads at once.
// ============================================================================
module ite_data_mem #(
   parameter int unsigned MEM_DEPTH = ite_pkg::MEM_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         adv,
   input  logic                         wr_en,
   input  logic [7:0]                   wr_byte,
   input  logic [$clog2(MEM_DEPTH)-1:0] lane_addr [ite_pkg::NUM_LANES],
   output logic [7:0]                   rd_byte_ff [ite_pkg::NUM_LANES]
);
   import ite_pkg::*;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      logic [7:0] mem [MEM_DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[lane_addr[0]] <= wr_byte;
         end
         if (adv) begin
            rd_byte_ff[g] <= mem[lane_addr[g]];
         end
      end
   end

endmodule

### rtl/rv32i_itype_execute_unit.sv
// ============================================================================
// rv32i_itype_execute_unit: I-type execute unit
// OP-IMM, loads and JALR against a register file and a byte memory, plus
// host preload of registers and memory bytes. One result item per item.
// ============================================================================
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+-----------------------------
//   req      | in  | req_valid / req_stall | ite_pkg::req_type
//   rsp      | out | rsp_valid / rsp_stall | ite_pkg::rsp_type
//
// One item per cycle sustained while rsp_stall stays low and no load hazard
// holds the execute stage. An item passes six register stages: execute,
// four address-reduction stages and the result stage, which also holds
// the memory read.
// An instruction whose rs1 comes from a load still in flight waits in the
// execute stage until that load retires; all other results are forwarded
// from the stage that holds them.
// Reset clears control state and the register file valid bits; the data
// memory is not cleared. rsp_stall freezes the whole pipe while the result
// stage holds an item; req_stall rises only when the execute stage holds
// an item that cannot move on.
// ============================================================================
module rv32i_itype_execute_unit #(
   parameter int unsigned MEM_DEPTH = ite_pkg::MEM_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ite_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ite_pkg::rsp_type rsp_data
);
   import ite_pkg::*;

   localparam int unsigned AW        = $clog2(MEM_DEPTH);
   localparam int unsigned NumStages = 5;
   localparam int unsigned LastStage = NumStages - 1;
   localparam int unsigned MemStage  = NumStages - 2;

   // ---------------------------------------------------------------------
   // Execute stage holding register and pipe behind it
   // ---------------------------------------------------------------------
   req_type  e1_ff;
   logic     e1_valid_ff, e1_valid_in;
   pipe_type pipe_ff [NumStages];
   logic [NumStages-1:0] pv_ff, pv_in;

   logic adv;         // whole pipe moves this cycle
   logic hazard;      // rs1 waits on a load in flight
   logic e1_move;
   logic req_accept;

   logic [REG_IDX_W-1:0] rs1;
   logic [REG_IDX_W-1:0] rf_rd_idx;
   logic [XLEN-1:0]      rf_rd_data;
   logic                 rf_wr_en;
   logic [XLEN-1:0]      rf_wr_data;

   logic            fwd_hit, fwd_load;
   logic [XLEN-1:0] fwd_val;
   logic [XLEN-1:0] op_a;
   logic [XLEN-1:0] ea;
   pipe_type        e1_item;

   logic [AW-1:0] lane_addr [NUM_LANES];
   logic [7:0]    rd_byte [NUM_LANES];
   logic          mem_wr_en;
   logic [XLEN-1:0] ld_val;
   logic [XLEN-1:0] wb_val;

   // ---------------------------------------------------------------------
   // Flow control. The result stage doubles as the output register.
   // ---------------------------------------------------------------------
   assign adv        = !pv_ff[LastStage] || !rsp_stall;
   assign e1_move    = e1_valid_ff && adv && !hazard;
   assign req_stall  = e1_valid_ff && !e1_move;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      e1_valid_in = e1_valid_ff;
      if (req_accept) begin
         e1_valid_in = 1'b1;
      end else if (e1_move) begin
         e1_valid_in = 1'b0;
      end
   end

   always_comb begin
      pv_in = pv_ff;
      if (adv) begin
         pv_in = {pv_ff[NumStages-2:0], e1_move};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         pv_ff       <= '0;
      end else begin
         e1_valid_ff <= e1_valid_in;
         pv_ff       <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         e1_ff <= req_data;
      end
      if (adv) begin
         pipe_ff[0] <= e1_item;
         for (int s = 1; s < NumStages; s++) begin
            pipe_ff[s] <= pipe_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Register file: read every cycle for whatever sits in execute next
   // ---------------------------------------------------------------------
   assign rs1       = e1_ff.instruction[19:15];
   assign rf_rd_idx = req_accept ? req_data.instruction[19:15] : rs1;

   ite_regfile u_regfile (
      .clock      (clock),
      .reset      (reset),
      .rd_idx     (rf_rd_idx),
      .rd_data_ff (rf_rd_data),
      .wr_en      (rf_wr_en),
      .wr_idx     (pipe_ff[LastStage].rf_idx),
      .wr_data    (rf_wr_data)
   );

   // Forwarding: youngest matching writer wins; loads are not ready yet
   always_comb begin
      fwd_hit  = 1'b0;
      fwd_load = 1'b0;
      fwd_val  = '0;
      for (int s = NumStages - 1; s >= 0; s--) begin
         if (pv_ff[s] && pipe_ff[s].rf_we && (pipe_ff[s].rf_idx == rs1)) begin
            fwd_hit  = 1'b1;
            fwd_load = pipe_ff[s].is_load;
            fwd_val  = pipe_ff[s].rf_val;
         end
      end
   end

   assign hazard = e1_valid_ff && (e1_ff.operation == OP_EXEC) && fwd_hit && fwd_load;
   assign op_a   = fwd_hit ? fwd_val : rf_rd_data;

   // ---------------------------------------------------------------------
   // Execute: decode, ALU, effective address, next pc
   // ---------------------------------------------------------------------
   always_comb begin
      logic [6:0]           opcode;
      logic [2:0]           f3;
      logic [6:0]           f7;
      logic [REG_IDX_W-1:0] rd;
      logic [XLEN-1:0]      imm;
      logic [4:0]           sh;
      logic                 wr;
      logic                 ld;
      logic [XLEN-1:0]      val;
      logic [XLEN-1:0]      pc4;
      opcode  = e1_ff.instruction[6:0];
      f3      = e1_ff.instruction[14:12];
      f7      = e1_ff.instruction[31:25];
      rd      = e1_ff.instruction[11:7];
      imm     = {{20{e1_ff.instruction[31]}}, e1_ff.instruction[31:20]};
      sh      = e1_ff.instruction[24:20];
      pc4     = e1_ff.current_pc + XLEN'(4);
      wr      = 1'b0;
      ld      = 1'b0;
      val     = '0;
      ea      = op_a + imm;
      e1_item = '0;

      case (e1_ff.operation)
         OP_EXEC: begin
            e1_item.npc = pc4;
            case (opcode)
               OPC_OPIMM: begin
                  wr = 1'b1;
                  case (f3)
                     F3_ADDI:  val = op_a + imm;
                     F3_SLLI: begin
                        if (f7 == F7_BASE) begin
                           val = op_a << sh;
                        end else begin
                           wr = 1'b0;
                           e1_item.status = 1'b1;
                        end
                     end
                     F3_SLTI:  val = XLEN'($signed(op_a) < $signed(imm));
                     F3_SLTIU: val = XLEN'(op_a < imm);
                     F3_XORI:  val = op_a ^ imm;
                     F3_SRXI: begin
                        if (f7 == F7_BASE) begin
                           val = op_a >> sh;
                        end else if (f7 == F7_SRA) begin
                           val = XLEN'($signed(op_a) >>> sh);
                        end else begin
                           wr = 1'b0;
                           e1_item.status = 1'b1;
                        end
                     end
                     F3_ORI:   val = op_a | imm;
                     default:  val = op_a & imm;
                  endcase
               end
               OPC_LOAD: begin
                  case (f3)
                     F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU: begin
                        wr = 1'b1;
                        ld = 1'b1;
                     end
                     default: e1_item.status = 1'b1;
                  endcase
               end
               OPC_JALR: begin
                  if (f3 == F3_JALR) begin
                     wr          = 1'b1;
                     val         = pc4;
                     e1_item.npc = {ea[XLEN-1:1], 1'b0};
                  end else begin
                     e1_item.status = 1'b1;
                  end
               end
               default: e1_item.status = 1'b1;
            endcase
            // x0 as destination: nothing written, nothing reported
            e1_item.rf_we   = wr && (rd != '0);
            e1_item.out_wr  = e1_item.rf_we;
            e1_item.rf_idx  = e1_item.rf_we ? rd : '0;
            e1_item.rf_val  = e1_item.rf_we ? val : '0;
            e1_item.is_load = ld;
            e1_item.ld_f3   = f3;
         end
         OP_MEM_WR: begin
            e1_item.host_mem  = 1'b1;
            e1_item.host_byte = e1_ff.host_data[7:0];
            ea = XLEN'(e1_ff.host_address);
         end
         OP_REG_WR: begin
            // silent register preload, result reports nothing
            e1_item.rf_we  = (e1_ff.host_address[15:REG_IDX_W] == '0) &&
                             (e1_ff.host_address[REG_IDX_W-1:0] != '0);
            e1_item.rf_idx = e1_ff.host_address[REG_IDX_W-1:0];
            e1_item.rf_val = e1_ff.host_data;
         end
         default: e1_item.status = 1'b1;
      endcase
   end

   // ---------------------------------------------------------------------
   // Address reduction and byte memory
   // ---------------------------------------------------------------------
   ite_addr_mod #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_addr_mod (
      .clock        (clock),
      .adv          (adv),
      .ea_in        (ea),
      .lane_addr_ff (lane_addr)
   );

   assign mem_wr_en = adv && pv_ff[MemStage] && pipe_ff[MemStage].host_mem;

   ite_data_mem #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_data_mem (
      .clock      (clock),
      .adv        (adv),
      .wr_en      (mem_wr_en),
      .wr_byte    (pipe_ff[MemStage].host_byte),
      .lane_addr  (lane_addr),
      .rd_byte_ff (rd_byte)
   );

   // ---------------------------------------------------------------------
   // Result stage: load formatting, writeback, result item
   // ---------------------------------------------------------------------
   always_comb begin
      case (pipe_ff[LastStage].ld_f3)
         F3_LB:   ld_val = {{24{rd_byte[0][7]}}, rd_byte[0]};
         F3_LH:   ld_val = {{16{rd_byte[1][7]}}, rd_byte[1], rd_byte[0]};
         F3_LW:   ld_val = {rd_byte[3], rd_byte[2], rd_byte[1], rd_byte[0]};
         F3_LBU:  ld_val = {24'd0, rd_byte[0]};
         F3_LHU:  ld_val = {16'd0, rd_byte[1], rd_byte[0]};
         default: ld_val = '0;
      endcase
   end

   assign wb_val     = pipe_ff[LastStage].is_load ? ld_val : pipe_ff[LastStage].rf_val;
   assign rf_wr_en   = pv_ff[LastStage] && !rsp_stall && pipe_ff[LastStage].rf_we;
   assign rf_wr_data = wb_val;

   assign rsp_valid = pv_ff[LastStage];

   always_comb begin
      rsp_data             = '0;
      rsp_data.reg_written = pipe_ff[LastStage].out_wr;
      rsp_data.next_pc     = pipe_ff[LastStage].npc;
      rsp_data.status      = pipe_ff[LastStage].status;
      if (pipe_ff[LastStage].out_wr) begin
         rsp_data.dest_index = pipe_ff[LastStage].rf_idx;
         rsp_data.dest_value = wb_val;
      end
   end

endmodule

### rtl/ite_checker.sv
// ============================================================================
// ite_checker: port-level checks for the I-type execute unit
// Bound to the top level; watches result items and reset behavior.
// ============================================================================
module ite_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ite_pkg::rsp_type rsp_data
);
   import ite_pkg::*;

   // pipe is empty and open right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result item or request stall present after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reg_written |->
         (rsp_data.dest_index == '0) && (rsp_data.dest_value == '0))
      else $error("destination fields set without a register write");

   a_no_x0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reg_written |-> (rsp_data.dest_index != '0))
      else $error("write to x0 reported");

   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> !rsp_data.reg_written)
      else $error("register written by an unsupported encoding");

endmodule

bind rv32i_itype_execute_unit ite_checker u_ite_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
